// File: hdl/assert_macros.svh
// assertion macros shared by the rtl of the pixel map block
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, a, b)
`define ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

// File: hdl/p2e_pkg.sv
// types, constants and arctangent table for the pinhole to equirect pixel map
// no dependencies
`timescale 1ns / 1ps
package p2e_pkg;
   localparam int COORD_BITS   = 12;
   localparam int COEFF_BITS   = 21;
   localparam int CORDIC_STEPS = 20;
   localparam int DOT_BITS     = 40;
   localparam int VEC_BITS     = 34;
   localparam int ANG_BITS     = 32;
   localparam int CSR_IDX_BITS = 3;
   localparam int CSR_DATA_BITS = 63;
   localparam int SIZE_BITS    = 13;
   localparam int PIPE_DEPTH   = 5 + 2 * CORDIC_STEPS;

   localparam logic signed [ANG_BITS-1:0] ANG_PI = 32'sd268435456;
   localparam logic [30:0] GAIN_Q30 = 31'd1768195363;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_ROW0 = 3'd0, CSR_ROW1 = 3'd1, CSR_ROW2 = 3'd2,
      CSR_WIDTH = 3'd3, CSR_HEIGHT = 3'd4
   } csr_idx_type;

   typedef struct packed {
      logic [11:0] col;
      logic [11:0] row;
   } req_word_type;

   typedef struct packed {
      logic [11:0] pano_x;
      logic [11:0] pano_y;
   } rsp_word_type;

   typedef struct packed {
      logic signed [VEC_BITS-1:0] x;
      logic signed [VEC_BITS-1:0] y;
      logic signed [ANG_BITS-1:0] z;
   } cordic_state_type;

   function automatic logic signed [ANG_BITS-1:0] atan_entry(input int i);
      logic signed [ANG_BITS-1:0] t;
      case (i)
         0: t = 32'sd67108864;  1: t = 32'sd39616676;  2: t = 32'sd20932363;
         3: t = 32'sd10625594;  4: t = 32'sd5333416;   5: t = 32'sd2669308;
         6: t = 32'sd1334980;   7: t = 32'sd667531;    8: t = 32'sd333770;
         9: t = 32'sd166886;    10: t = 32'sd83443;    11: t = 32'sd41722;
         12: t = 32'sd20861;    13: t = 32'sd10430;    14: t = 32'sd5215;
         15: t = 32'sd2608;     16: t = 32'sd1304;     17: t = 32'sd652;
         18: t = 32'sd326;      19: t = 32'sd163;      20: t = 32'sd81;
         21: t = 32'sd41;       22: t = 32'sd20;       23: t = 32'sd10;
         24: t = 32'sd5;        25: t = 32'sd3;        26: t = 32'sd1;
         27: t = 32'sd1;        default: t = '0;
      endcase
      return t;
   endfunction

   // total angle the cordic chain subtracts when y stays zero
   function automatic logic signed [ANG_BITS-1:0] atan_sum();
      logic signed [ANG_BITS-1:0] s;
      s = '0;
      for (int i = 0; i < CORDIC_STEPS; i++) s = s + atan_entry(i);
      return s;
   endfunction

   localparam logic signed [ANG_BITS-1:0] ATAN_SUM = atan_sum();
endpackage

// File: hdl/p2e_cordic_stage.sv
// one registered cordic vectoring iteration with the shift set by the step input
// depends on p2e_pkg
`timescale 1ns / 1ps
module p2e_cordic_stage (
   input  logic                      clock,
   input  logic [4:0]                step,
   input  p2e_pkg::cordic_state_type in_state,
   output p2e_pkg::cordic_state_type out_state_ff
);
   import p2e_pkg::*;
   cordic_state_type out_state_in;
   logic signed [VEC_BITS-1:0] sx, sy;

   always_comb begin
      sx = in_state.y >>> step;
      sy = in_state.x >>> step;
      if (in_state.y > 0) begin
         out_state_in.x = in_state.x + sx;
         out_state_in.y = in_state.y - sy;
         out_state_in.z = in_state.z + atan_entry(int'(step));
      end else begin
         out_state_in.x = in_state.x - sx;
         out_state_in.y = in_state.y + sy;
         out_state_in.z = in_state.z - atan_entry(int'(step));
      end
   end

   always_ff @(posedge clock) begin
      out_state_ff <= out_state_in;
   end
endmodule

// File: hdl/pinhole_to_equirect_pixel_map.sv
// top level: maps a virtual camera pixel to an equirectangular panorama pixel
// depends on p2e_pkg, p2e_cordic_stage and assert_macros.svh
// One word is taken each clock that start is high and busy is low; busy is held low,
// so a raster runs at one pixel per cycle. Each result appears on rsp_valid for one
// cycle; it passes the two 20-step cordic chains (one register per step) and a
// register each for the matrix product, normalization, shift and quadrant fold,
// gain multiply and panorama scaling. The receiver cannot stall, so nothing waits
// inside. The user must write matrix and size registers only while no pixel is in
// flight; the block itself does not enforce this.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module pinhole_to_equirect_pixel_map (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  p2e_pkg::req_word_type               req_word,
   output logic                                rsp_valid,
   output p2e_pkg::rsp_word_type               rsp_word,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [p2e_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [p2e_pkg::CSR_DATA_BITS-1:0]   csr_data
);
   import p2e_pkg::*;

   logic [CSR_DATA_BITS-1:0] row_ff [3];
   logic [SIZE_BITS-1:0] width_ff, height_ff;
   logic [PIPE_DEPTH-1:0] valid_ff;

   assign busy = 1'b0;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff[0] <= '0; row_ff[1] <= '0; row_ff[2] <= '0;
         width_ff <= 13'd4096;
         height_ff <= 13'd2048;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_ROW0:   row_ff[0] <= csr_data;
            CSR_ROW1:   row_ff[1] <= csr_data;
            CSR_ROW2:   row_ff[2] <= csr_data;
            CSR_WIDTH:  width_ff  <= csr_data[SIZE_BITS-1:0];
            CSR_HEIGHT: height_ff <= csr_data[SIZE_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= '0;
      else valid_ff <= {valid_ff[PIPE_DEPTH-2:0], start};
   end

   // stage 1: matrix product
   logic signed [DOT_BITS-1:0] d_in [3], d_ff [3];
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         d_in[r] = DOT_BITS'(signed'(row_ff[r][COEFF_BITS-1:0])) *
                   DOT_BITS'(signed'({1'b0, req_word.col[COORD_BITS-1:0]}))
                 + DOT_BITS'(signed'(row_ff[r][2*COEFF_BITS-1:COEFF_BITS])) *
                   DOT_BITS'(signed'({1'b0, req_word.row[COORD_BITS-1:0]}))
                 + DOT_BITS'(signed'(row_ff[r][3*COEFF_BITS-1:2*COEFF_BITS]));
      end
   end
   always_ff @(posedge clock) d_ff <= d_in;

   // stage 2: find normalization shift (top bit of largest magnitude)
   logic [DOT_BITS-1:0] mag_or;
   logic [5:0] lead_in, lead_ff;
   logic zero_in, zero_ff;
   logic signed [DOT_BITS-1:0] d2_ff [3];
   always_comb begin
      mag_or = '0;
      for (int r = 0; r < 3; r++)
         mag_or = mag_or | (d_ff[r][DOT_BITS-1] ? DOT_BITS'(-d_ff[r]) : d_ff[r]);
      lead_in = '0;
      for (int b = 0; b < DOT_BITS; b++)
         if (mag_or[b]) lead_in = 6'(b);
      zero_in = (mag_or == '0);
   end
   always_ff @(posedge clock) begin
      lead_ff <= lead_in; zero_ff <= zero_in; d2_ff <= d_ff;
   end

   // stage 3: shift to [2^28,2^29), quadrant fold
   logic signed [VEC_BITS-1:0] n_v [3];
   cordic_state_type pan0_in, pan0_ff;
   logic signed [VEC_BITS-1:0] nz_ff;
   logic zero3_ff;
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         if (lead_ff >= 6'd28) n_v[r] = VEC_BITS'(d2_ff[r] >>> (lead_ff - 6'd28));
         else n_v[r] = VEC_BITS'(d2_ff[r] <<< (6'd28 - lead_ff));
      end
      if (n_v[0] == 0 && n_v[1] == 0) begin
         // no horizontal part: every step subtracts, so start at the total to end at 0
         pan0_in.x = '0; pan0_in.y = '0; pan0_in.z = ATAN_SUM;
      end else if (n_v[0] < 0 && n_v[1] >= 0) begin
         pan0_in.x = n_v[1]; pan0_in.y = -n_v[0]; pan0_in.z = ANG_PI >>> 1;
      end else if (n_v[0] < 0) begin
         pan0_in.x = -n_v[1]; pan0_in.y = n_v[0]; pan0_in.z = -(ANG_PI >>> 1);
      end else begin
         pan0_in.x = n_v[0]; pan0_in.y = n_v[1]; pan0_in.z = '0;
      end
   end
   always_ff @(posedge clock) begin
      pan0_ff <= pan0_in; nz_ff <= n_v[2]; zero3_ff <= zero_ff;
   end

   // pan cordic chain, z and zero flag ride alongside
   cordic_state_type pan_s [CORDIC_STEPS+1];
   logic signed [VEC_BITS-1:0] zc_ff [CORDIC_STEPS+1];
   logic zf_ff [CORDIC_STEPS+1];
   assign pan_s[0] = pan0_ff;
   always_comb begin
      zc_ff[0] = nz_ff; zf_ff[0] = zero3_ff;
   end
   for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_pan
      p2e_cordic_stage u_stage (.clock(clock), .step(5'(g)), .in_state(pan_s[g]),
         .out_state_ff(pan_s[g+1]));
      always_ff @(posedge clock) begin
         zc_ff[g+1] <= zc_ff[g]; zf_ff[g+1] <= zf_ff[g];
      end
   end

   // gain multiply on z; hyp zero when x and y were zero (x stays 0 through cordic)
   logic [VEC_BITS-1:0] zmag;
   logic [63:0] zprod;
   logic signed [VEC_BITS-1:0] zk;
   cordic_state_type tilt0_in, tilt0_ff;
   logic signed [ANG_BITS-1:0] pan_in, pan_ff;
   logic zero4_ff;
   always_comb begin
      zmag = zc_ff[CORDIC_STEPS][VEC_BITS-1] ? VEC_BITS'(-zc_ff[CORDIC_STEPS])
                                            : zc_ff[CORDIC_STEPS];
      zprod = 64'(zmag[29:0]) * 64'(GAIN_Q30) + 64'(1) * (64'd1 << 29);
      zk = zc_ff[CORDIC_STEPS][VEC_BITS-1] ? -VEC_BITS'(zprod[63:30])
                                          : VEC_BITS'(zprod[63:30]);
      tilt0_in.x = pan_s[CORDIC_STEPS].x;
      tilt0_in.y = zk;
      tilt0_in.z = '0;
      pan_in = pan_s[CORDIC_STEPS].z;
   end
   always_ff @(posedge clock) begin
      tilt0_ff <= tilt0_in; zero4_ff <= zf_ff[CORDIC_STEPS];
   end

   cordic_state_type tilt_s [CORDIC_STEPS+1];
   logic signed [ANG_BITS-1:0] pc_ff [CORDIC_STEPS+1];
   logic tz_ff [CORDIC_STEPS+1];
   assign tilt_s[0] = tilt0_ff;
   always_ff @(posedge clock) pc_ff[0] <= pan_in;
   always_comb tz_ff[0] = zero4_ff;
   for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_tilt
      p2e_cordic_stage u_stage (.clock(clock), .step(5'(g)), .in_state(tilt_s[g]),
         .out_state_ff(tilt_s[g+1]));
      always_ff @(posedge clock) begin
         pc_ff[g+1] <= pc_ff[g]; tz_ff[g+1] <= tz_ff[g];
      end
   end

   // final: clamp angles and scale to panorama size
   logic signed [ANG_BITS:0] a_v, b_v;
   logic [29:0] a_c;
   logic [28:0] b_c;
   logic [11:0] wm, hm;
   logic [41:0] xp, yp;
   rsp_word_type rsp_in, rsp_ff;
   logic signed [ANG_BITS-1:0] panf, tiltf;
   always_comb begin
      panf  = tz_ff[CORDIC_STEPS] ? '0 : pc_ff[CORDIC_STEPS];
      tiltf = tz_ff[CORDIC_STEPS] ? '0 : tilt_s[CORDIC_STEPS].z;
      a_v = 33'(ANG_PI) - 33'(panf);
      b_v = 33'(ANG_PI >>> 1) - 33'(tiltf);
      a_c = (a_v < 0) ? '0 : (a_v > 33'sd536870912) ? 30'd536870912 : a_v[29:0];
      b_c = (b_v < 0) ? '0 : (b_v > 33'sd268435456) ? 29'd268435456 : b_v[28:0];
      wm = (width_ff == '0) ? '0 : (width_ff > 13'd4096) ? 12'hfff : 12'(width_ff - 13'd1);
      hm = (height_ff == '0) ? '0 : (height_ff > 13'd4096) ? 12'hfff : 12'(height_ff - 13'd1);
      xp = 42'(a_c) * 42'(wm) + (42'd1 << 28);
      yp = 42'(b_c) * 42'(hm) + (42'd1 << 27);
      rsp_in.pano_x = xp[40:29];
      rsp_in.pano_y = yp[39:28];
   end
   always_ff @(posedge clock) rsp_ff <= rsp_in;

   assign rsp_word = rsp_ff;
   assign rsp_valid = valid_ff[PIPE_DEPTH-1];

   `ASSERT_NEXT(a_valid_moves, clock, reset, start, valid_ff[0])
   `ASSERT_IMPLIES(a_never_busy, clock, reset, 1'b1, !busy)
   `ASSERT_IMPLIES(a_x_in_range, clock, reset, rsp_valid, rsp_word.pano_x <= 12'hfff)
endmodule

// File: bench/p2e_map_checker.sv
// checker for the pinhole to equirect pixel map: tracks csr writes, predicts each
// panorama pixel and compares results in order; depends on p2e_pkg
`timescale 1ns / 1ps
module p2e_map_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic                              busy,
   input  p2e_pkg::req_word_type             req_word,
   input  logic                              rsp_valid,
   input  p2e_pkg::rsp_word_type             rsp_word,
   input  logic                              csr_valid,
   input  logic                              csr_ready,
   input  logic [p2e_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [p2e_pkg::CSR_DATA_BITS-1:0] csr_data,
   output int                                errors,
   output int                                pending,
   output int                                matched
);
   import p2e_pkg::*;

   localparam longint HALF_TURN = 64'sd268435456;

   logic [62:0] mat_row [0:2];
   logic [12:0] width_reg, height_reg;
   rsp_word_type expected_maps[$];

   function automatic longint atan_q28(input int i);
      longint t;
      case (i)
         0: t = 67108864;  1: t = 39616676;  2: t = 20932363;  3: t = 10625594;
         4: t = 5333416;   5: t = 2669308;   6: t = 1334980;   7: t = 667531;
         8: t = 333770;    9: t = 166886;    10: t = 83443;    11: t = 41722;
         12: t = 20861;    13: t = 10430;    14: t = 5215;     15: t = 2608;
         16: t = 1304;     17: t = 652;      18: t = 326;      19: t = 163;
         default: t = 0;
      endcase
      return t;
   endfunction

   function automatic longint coeff_of(input logic [62:0] rv, input int k);
      logic signed [20:0] c;
      c = rv[k*21 +: 21];
      return longint'(c);
   endfunction

   function automatic longint abs_of(input longint v);
      return (v < 0) ? -v : v;
   endfunction

   // vectoring rotation: drives vy to zero, accumulates angle
   function automatic longint rotate_to_axis(input longint vx, input longint vy,
                                             input longint z0, output longint mag);
      longint sx, sy, acc;
      acc = z0;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         sx = vy >>> i;
         sy = vx >>> i;
         if (vy > 0) begin
            vx = vx + sx; vy = vy - sy; acc = acc + atan_q28(i);
         end else begin
            vx = vx - sx; vy = vy + sy; acc = acc - atan_q28(i);
         end
      end
      mag = vx;
      return acc;
   endfunction

   function automatic longint size_span(input logic [12:0] n);
      longint m;
      m = (n == 0) ? 0 : longint'(n) - 1;
      return (m > 4095) ? 4095 : m;
   endfunction

   function automatic rsp_word_type map_pixel(input req_word_type w);
      longint c, r, dx, dy, dz, m, pan, tilt, hyp, zk, zm, unused, a, b;
      int rs, ls;
      rsp_word_type o;
      c = longint'(w.col);
      r = longint'(w.row);
      dx = coeff_of(mat_row[0], 0) * c + coeff_of(mat_row[0], 1) * r + coeff_of(mat_row[0], 2);
      dy = coeff_of(mat_row[1], 0) * c + coeff_of(mat_row[1], 1) * r + coeff_of(mat_row[1], 2);
      dz = coeff_of(mat_row[2], 0) * c + coeff_of(mat_row[2], 1) * r + coeff_of(mat_row[2], 2);
      pan = 0;
      tilt = 0;
      m = abs_of(dx);
      if (abs_of(dy) > m) m = abs_of(dy);
      if (abs_of(dz) > m) m = abs_of(dz);
      if (m != 0) begin
         rs = 0;
         ls = 0;
         while (m >= 2 * HALF_TURN) begin m = m >> 1; rs++; end
         while (m < HALF_TURN) begin m = m << 1; ls++; end
         dx = (dx >>> rs) <<< ls;
         dy = (dy >>> rs) <<< ls;
         dz = (dz >>> rs) <<< ls;
         if (dx == 0 && dy == 0) hyp = 0;
         else if (dx < 0 && dy >= 0) pan = rotate_to_axis(dy, -dx, HALF_TURN / 2, hyp);
         else if (dx < 0) pan = rotate_to_axis(-dy, dx, -(HALF_TURN / 2), hyp);
         else pan = rotate_to_axis(dx, dy, 0, hyp);
         zm = (abs_of(dz) * longint'(GAIN_Q30) + (64'sd1 << 29)) >>> 30;
         zk = (dz < 0) ? -zm : zm;
         tilt = rotate_to_axis(hyp, zk, 0, unused);
      end
      a = HALF_TURN - pan;
      b = HALF_TURN / 2 - tilt;
      if (a < 0) a = 0;
      if (a > 2 * HALF_TURN) a = 2 * HALF_TURN;
      if (b < 0) b = 0;
      if (b > HALF_TURN) b = HALF_TURN;
      a = (a * size_span(width_reg) + (64'sd1 << 28)) >>> 29;
      b = (b * size_span(height_reg) + (64'sd1 << 27)) >>> 28;
      o.pano_x = a[11:0];
      o.pano_y = b[11:0];
      return o;
   endfunction

   always @(posedge clock) begin
      rsp_word_type want;
      if (reset) begin
         mat_row[0] <= '0;
         mat_row[1] <= '0;
         mat_row[2] <= '0;
         width_reg  <= 13'd4096;
         height_reg <= 13'd2048;
         errors <= 0;
         matched <= 0;
         expected_maps.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_idx_type'(csr_index))
               CSR_ROW0:   mat_row[0] <= csr_data;
               CSR_ROW1:   mat_row[1] <= csr_data;
               CSR_ROW2:   mat_row[2] <= csr_data;
               CSR_WIDTH:  width_reg  <= csr_data[12:0];
               CSR_HEIGHT: height_reg <= csr_data[12:0];
               default: ;
            endcase
         end
         if (start && !busy) expected_maps.push_back(map_pixel(req_word));
         if (rsp_valid) begin
            if (expected_maps.size() == 0) begin
               $display("%0t: unexpected result word: expected none, actual x=%0d y=%0d",
                        $time, rsp_word.pano_x, rsp_word.pano_y);
               errors <= errors + 1;
            end else begin
               want = expected_maps.pop_front();
               if (want.pano_x !== rsp_word.pano_x || want.pano_y !== rsp_word.pano_y) begin
                  $display("%0t: mismatch: expected x=%0d y=%0d, actual x=%0d y=%0d",
                           $time, want.pano_x, want.pano_y, rsp_word.pano_x,
                           rsp_word.pano_y);
                  errors <= errors + 1;
               end else begin
                  matched <= matched + 1;
               end
            end
         end
      end
   end

   assign pending = expected_maps.size();
endmodule

// File: bench/tb_pinhole_to_equirect_pixel_map.sv
// testbench top for the pinhole to equirect pixel map: drives pixels and csr writes
// across several matrix and panorama settings; depends on p2e_pkg and p2e_map_checker
`timescale 1ns / 1ps
module tb_pinhole_to_equirect_pixel_map;
   import p2e_pkg::*;

   localparam int IDLE_LIMIT = 2000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   req_word_type req_word = '0;
   logic rsp_valid;
   rsp_word_type rsp_word;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_data = '0;
   int errors, pending, matched;
   int pixels_sent = 0, csr_writes = 0, idle_cycles = 0;
   bit steady;

   always #1 clock = ~clock;

   pinhole_to_equirect_pixel_map DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_word(rsp_word), .csr_valid(csr_valid),
      .csr_ready(csr_ready), .csr_index(csr_index), .csr_data(csr_data)
   );

   p2e_map_checker map_check (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_word(rsp_word), .csr_valid(csr_valid),
      .csr_ready(csr_ready), .csr_index(csr_index), .csr_data(csr_data),
      .errors(errors), .pending(pending), .matched(matched)
   );

   // watchdog on cycles with no handshake of any kind
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [62:0] pack_row(input int a, input int b, input int c);
      logic [20:0] ua, ub, uc;
      ua = a[20:0];
      ub = b[20:0];
      uc = c[20:0];
      return {uc, ub, ua};
   endfunction

   function automatic logic [62:0] rand_row();
      return 63'({$urandom(), $urandom()});
   endfunction

   function automatic int rand_coeff(input int span);
      return $urandom_range(0, 2 * span) - span;
   endfunction

   task automatic send_pixel(input logic [11:0] c, input logic [11:0] r);
      int g;
      g = gap_len();
      if (g > 0) begin
         start <= 1'b0;
         repeat (g) @(posedge clock);
      end
      start <= 1'b1;
      req_word <= '{col: c, row: r};
      do @(posedge clock); while (busy);
      pixels_sent++;
   endtask

   // leaves csr_valid high; the caller drops it after the last write
   task automatic write_csr(input csr_idx_type idx, input logic [62:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_writes++;
   endtask

   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      @(posedge clock);
   endtask

   task automatic load_setup(input logic [62:0] r0, input logic [62:0] r1,
                             input logic [62:0] r2, input logic [12:0] w,
                             input logic [12:0] h);
      drain();
      write_csr(CSR_ROW0, r0);
      write_csr(CSR_ROW1, r1);
      write_csr(CSR_ROW2, r2);
      write_csr(CSR_WIDTH, {50'd0, w});
      write_csr(CSR_HEIGHT, {50'd0, h});
      csr_valid <= 1'b0;
   endtask

   task automatic random_pixels(input int n);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 49) == 0) steady = !steady;
         send_pixel(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)));
      end
      steady = 0;
   endtask

   function automatic logic [12:0] rand_size();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 13'($urandom_range(0, 8191));
      if (r == 1) return 13'd1;
      return 13'($urandom_range(1, 4096));
   endfunction

   initial begin
      int f, cx, cy;
      steady = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: zero matrix gives the zero ray
      send_pixel(12'd0, 12'd0);
      send_pixel(12'hfff, 12'hfff);
      send_pixel(12'h555, 12'haaa);

      // ray straight up or down: no horizontal part
      load_setup('0, '0, pack_row(1, -1, -3), 13'd4096, 13'd2048);
      send_pixel(12'd0, 12'd0);
      send_pixel(12'd0, 12'd4095);
      send_pixel(12'd4095, 12'd0);
      send_pixel(12'd3, 12'd0);
      random_pixels(40);

      // plain forward camera
      load_setup(pack_row(1, 0, -2048), pack_row(0, 1, -1024), pack_row(0, 0, 1500),
                 13'd4096, 13'd2048);
      send_pixel(12'd0, 12'd0);
      send_pixel(12'd4095, 12'd4095);
      send_pixel(12'd0, 12'd4095);
      send_pixel(12'd4095, 12'd0);
      send_pixel(12'd2048, 12'd1024);
      random_pixels(100);

      // coefficient extremes, one pixel wide panorama
      load_setup(pack_row(1048575, -1048576, 1048575), pack_row(-1048576, 1048575, -1048576),
                 pack_row(1048575, 1048575, -1048576), 13'd1, 13'd1);
      send_pixel(12'd0, 12'd0);
      send_pixel(12'd4095, 12'd4095);
      random_pixels(60);

      // zero size behaves as one
      load_setup(rand_row(), rand_row(), rand_row(), 13'd0, 13'd0);
      random_pixels(60);

      // camera looking backward, oversized panorama width
      load_setup(pack_row(-1, 0, 2048), pack_row(0, 1, -2048), pack_row(0, 0, -900),
                 13'd8191, 13'd4096);
      send_pixel(12'd2048, 12'd2048);
      send_pixel(12'd2048, 12'd0);
      send_pixel(12'd0, 12'd2048);
      random_pixels(100);

      // ignored register index, then random cameras and random matrices
      drain();
      write_csr(csr_idx_type'(3'd7), 63'({$urandom(), $urandom()}));
      csr_valid <= 1'b0;
      for (int p = 0; p < 10; p++) begin
         if (p % 2 == 0) begin
            f = $urandom_range(1, 4000);
            cx = $urandom_range(0, 4095);
            cy = $urandom_range(0, 4095);
            if ($urandom_range(0, 1)) f = -f;
            load_setup(pack_row(rand_coeff(4), rand_coeff(2), -cx),
                       pack_row(rand_coeff(2), rand_coeff(4), -cy),
                       pack_row(rand_coeff(1), rand_coeff(1), f), rand_size(), rand_size());
         end else begin
            load_setup(rand_row(), rand_row(), rand_row(), rand_size(), rand_size());
         end
         random_pixels(75);
      end

      drain();
      repeat (PIPE_DEPTH + 10) @(posedge clock);
      $display("covered %0d pixels and %0d register writes over 16 settings", pixels_sent,
               csr_writes);
      $display("results matched: %0d, left waiting: %0d", matched, pending);
      if (errors == 0 && pending == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule
